// File: design/assert_macros.svh
// Assertion macros shared by the checker files of the aligner.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RVCA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define RVCA_ASSERT(label, prop, msg) \
    `RVCA_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// File: design/rvca_pkg.sv
// Shared types, constants and helpers of the RVC instruction aligner.
// No dependencies; imported by every module of the block.
`default_nettype none

package rvca_pkg;

    localparam int HALF_W  = 16;
    localparam int BITS_W  = 32;
    localparam int ADDR_W  = 64;
    localparam int INDEX_W = 32;
    localparam int OFF_W   = 4;

    localparam logic [1:0] LOW2_MASK = 2'b11;
    localparam logic [OFF_W-1:0] STEP_COMP = 4'd2;
    localparam logic [OFF_W-1:0] STEP_FULL = 4'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port: one 64-bit register, byte address 8*index.
    localparam int CFG_DATA_W = 64;
    localparam int PADDR_W    = 4;
    localparam logic [0:0] REG_SECTION_BASE = 1'b0;

    typedef struct packed {
        logic [BITS_W-1:0]  bits;
        logic [ADDR_W-1:0]  address;
        logic [INDEX_W-1:0] index;
        logic               is_compressed;
        logic               truncated;
        logic               section_done;
        logic               run_last;
    } result_t;

    // All results caused by one fetch word: one or two.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } pair_t;

    typedef struct packed {
        logic                  wr;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    function automatic result_t make_result(
        input logic [BITS_W-1:0]  bits,
        input logic [ADDR_W-1:0]  address,
        input logic [INDEX_W-1:0] index,
        input logic               is_compressed,
        input logic               truncated,
        input logic               section_done,
        input logic               run_last
    );
        result_t r;
        r.bits          = bits;
        r.address       = address;
        r.index         = index;
        r.is_compressed = is_compressed;
        r.truncated     = truncated;
        r.section_done  = section_done;
        r.run_last      = run_last;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/rvca_front.sv
// Front end of the aligner: takes fetch words, splits them into halfwords
// and forms the results of each word. Holds section state. Uses rvca_pkg.
`default_nettype none

module rvca_front
    import rvca_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_wr_t               cfg,
    output logic [CFG_DATA_W-1:0]      section_base,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [BITS_W-1:0]     fetch_word,
    input  wire logic                  upper_valid,
    input  wire logic                  section_last,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output pair_t                      push_data
);

    logic [ADDR_W-1:0]  base_reg,       base_next;
    logic [HALF_W-1:0]  held_half_reg,  held_half_next;
    logic               held_valid_reg, held_valid_next;
    logic [ADDR_W-1:0]  address_reg,    address_next;
    logic [INDEX_W-1:0] index_reg,      index_next;

    logic [HALF_W-1:0] lo, hi;
    logic              e1, e2, e3;
    logic [BITS_W-1:0] b1, b2;
    logic              c1, c2;
    logic [OFF_W-1:0]  off1, off2;
    logic              hv1, hv2;
    logic [HALF_W-1:0] hh1, hh2;
    logic [ADDR_W-1:0] a2, a3;
    logic [1:0]        count;
    logic              two;
    result_t           r1, r2, r3;
    logic              accept;

    assign lo           = fetch_word[HALF_W-1:0];
    assign hi           = fetch_word[BITS_W-1:HALF_W];
    assign in_ready     = push_ready;
    assign accept       = in_valid && push_ready;
    assign section_base = base_reg;

    // Each halfword either completes a held start, is a 16-bit instruction,
    // or becomes a held start itself.
    always_comb begin
        if (held_valid_reg) begin
            e1 = 1'b1; b1 = {lo, held_half_reg}; c1 = 1'b0; off1 = STEP_FULL;
            hv1 = 1'b0; hh1 = held_half_reg;
        end else if (lo[1:0] != LOW2_MASK) begin
            e1 = 1'b1; b1 = {{HALF_W{1'b0}}, lo}; c1 = 1'b1; off1 = STEP_COMP;
            hv1 = 1'b0; hh1 = held_half_reg;
        end else begin
            e1 = 1'b0; b1 = {{HALF_W{1'b0}}, lo}; c1 = 1'b0; off1 = '0;
            hv1 = 1'b1; hh1 = lo;
        end

        if (!upper_valid) begin
            e2 = 1'b0; b2 = {{HALF_W{1'b0}}, hi}; c2 = 1'b0; off2 = off1;
            hv2 = hv1; hh2 = hh1;
        end else if (hv1) begin
            e2 = 1'b1; b2 = {hi, hh1}; c2 = 1'b0; off2 = off1 + STEP_FULL;
            hv2 = 1'b0; hh2 = hh1;
        end else if (hi[1:0] != LOW2_MASK) begin
            e2 = 1'b1; b2 = {{HALF_W{1'b0}}, hi}; c2 = 1'b1; off2 = off1 + STEP_COMP;
            hv2 = 1'b0; hh2 = hh1;
        end else begin
            e2 = 1'b0; b2 = {{HALF_W{1'b0}}, hi}; c2 = 1'b0; off2 = off1;
            hv2 = 1'b1; hh2 = hi;
        end

        e3 = section_last && hv2;
    end

    assign a2    = address_reg + {{(ADDR_W-OFF_W){1'b0}}, off1};
    assign a3    = address_reg + {{(ADDR_W-OFF_W){1'b0}}, off2};
    assign count = {1'b0, e1} + {1'b0, e2} + {1'b0, e3};
    assign two   = (count == 2'd2);

    // Flags and index are filled in per slot below.
    assign r1 = make_result(b1, address_reg, '0, c1, 1'b0, 1'b0, 1'b0);
    assign r2 = make_result(b2, a2, '0, c2, 1'b0, 1'b0, 1'b0);
    assign r3 = make_result({{HALF_W{1'b0}}, hh2}, a3, '0, 1'b0, 1'b1, 1'b0, 1'b0);

    always_comb begin
        if (e1)      push_data.first = r1;
        else if (e2) push_data.first = r2;
        else         push_data.first = r3;
        if (e1 && e2) push_data.second = r2;
        else          push_data.second = r3;

        push_data.first.index         = index_reg;
        push_data.first.run_last      = !two;
        push_data.first.section_done  = section_last && !two;
        push_data.second.index        = index_reg + 1'b1;
        push_data.second.run_last     = 1'b1;
        push_data.second.section_done = section_last;
        push_data.two                 = two;
    end

    assign push_valid = accept && (count != 2'd0);

    always_comb begin
        base_next       = base_reg;
        held_half_next  = held_half_reg;
        held_valid_next = held_valid_reg;
        address_next    = address_reg;
        index_next      = index_reg;
        if (cfg.wr) begin
            base_next       = cfg.data;
            held_valid_next = 1'b0;
            address_next    = cfg.data;
            index_next      = '0;
        end else if (accept) begin
            if (section_last) begin
                held_valid_next = 1'b0;
                address_next    = base_reg;
                index_next      = '0;
            end else begin
                held_half_next  = hh2;
                held_valid_next = hv2;
                address_next    = a3;
                index_next      = index_reg + {{(INDEX_W-2){1'b0}}, count};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= '0;
            held_valid_reg <= 1'b0;
            address_reg    <= '0;
            index_reg      <= '0;
        end else begin
            base_reg       <= base_next;
            held_valid_reg <= held_valid_next;
            address_reg    <= address_next;
            index_reg      <= index_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_half_reg <= held_half_next;
    end

endmodule

`default_nettype wire

// File: design/rvca_queue.sv
// Short queue of result pairs between the front and back of the aligner.
// Uses rvca_pkg for the entry type and depth.
`default_nettype none

module rvca_queue
    import rvca_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire pair_t push_data,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output pair_t      pop_data
);

    pair_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg,  count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)      count_next = count_reg + 1'b1;
        else if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/rvca_back.sv
// Back end of the aligner: turns queued result pairs into single output
// beats held in an output register. Uses rvca_pkg.
`default_nettype none

module rvca_back
    import rvca_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire pair_t pop_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_data
);

    result_t out_reg,        out_next;
    logic    out_valid_reg,  out_valid_next;
    result_t pend_reg,       pend_next;
    logic    pend_valid_reg, pend_valid_next;
    logic    load;

    // The output register may take a new beat when empty or being drained.
    assign load      = !out_valid_reg || out_ready;
    assign pop_ready = load && !pend_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (load) begin
            if (pend_valid_reg) begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end else if (pop_valid) begin
                out_next        = pop_data.first;
                out_valid_next  = 1'b1;
                pend_next       = pop_data.second;
                pend_valid_next = pop_data.two;
            end else begin
                out_valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// File: design/rvc_instruction_aligner.sv
// RVC instruction aligner. A word's results are registered in the pair queue
// and then the output register; a second result from one word waits in a
// pending register behind the first. One word is taken per cycle while the
// queue has room; the single output drains one beat per cycle while m_tready
// is high. A four-entry pair queue decouples input from output. Synchronous
// active-low reset clears all control state and sets section_base to zero.
`default_nettype none

module rvc_instruction_aligner
    import rvca_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // [31:0] fetch_word
    input  wire logic [0:0]            s_tuser,   // [0] upper_valid
    input  wire logic                  s_tlast,   // section_last
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [127:0]               m_tdata,   // [31:0] instr_bits,
                                                  // [95:32] instr_address,
                                                  // [127:96] instr_index
    output logic [2:0]                 m_tuser,   // [0] is_compressed,
                                                  // [1] truncated,
                                                  // [2] section_done
    output logic                       m_tlast,   // run_last
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    cfg_wr_t               cfg;
    logic [CFG_DATA_W-1:0] section_base;
    logic                  push_valid, push_ready, pop_valid, pop_ready;
    pair_t                 push_data, pop_data;
    result_t               out_data;
    logic                  reg_hit;

    // Registers lie every eight bytes; the low address bits are ignored.
    assign reg_hit  = (paddr[PADDR_W-1:3] == REG_SECTION_BASE);
    assign pready   = 1'b1;
    assign cfg.wr   = psel && penable && pwrite && reg_hit;
    assign cfg.data = pwdata;
    assign prdata   = reg_hit ? section_base : '0;

    rvca_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .section_base (section_base),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .fetch_word   (s_tdata),
        .upper_valid  (s_tuser[0]),
        .section_last (s_tlast),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    rvca_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rvca_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.index, out_data.address, out_data.bits};
    assign m_tuser = {out_data.section_done, out_data.truncated, out_data.is_compressed};
    assign m_tlast = out_data.run_last;

endmodule

`default_nettype wire

// File: design/rvca_checker.sv
// Port-level checks on the RVC instruction aligner, bound to the top level.
// Depends on assert_macros.svh and rvca_pkg.
`default_nettype none

`include "assert_macros.svh"

module rvca_checker
    import rvca_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [127:0]          m_tdata,
    input wire logic [2:0]            m_tuser,
    input wire logic                  m_tlast
);

    property p_out_hold;
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast);
    endproperty

    property p_trunc_not_comp;
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]);
    endproperty

    property p_trunc_at_end;
        m_tvalid && m_tuser[1] |-> m_tuser[2] && m_tlast;
    endproperty

    property p_comp_zext;
        m_tvalid && m_tuser[0] |-> m_tdata[31:16] == 16'h0000;
    endproperty

    // A stalled output beat keeps its contents.
    `RVCA_ASSERT(a_out_hold, p_out_hold, "stalled output beat changed")

    // A truncated start is never a compressed instruction.
    `RVCA_ASSERT(a_trunc_not_comp, p_trunc_not_comp, "truncated beat marked compressed")

    // A truncated start is always the final beat of its section and word.
    `RVCA_ASSERT(a_trunc_at_end, p_trunc_at_end, "truncated beat not at section end")

    // The end of a section is also the end of the word's run.
    `RVCA_ASSERT(a_done_is_last, m_tvalid && m_tuser[2] |-> m_tlast, "section end without run end")

    // A 16-bit instruction is zero-extended.
    `RVCA_ASSERT(a_comp_zext, p_comp_zext, "compressed instruction not zero-extended")

endmodule

bind rvc_instruction_aligner rvca_checker u_rvca_checker (.*);

`default_nettype wire
